// File: rtl/lru_pr_pkg.sv
// shared constants, types and helpers for the lru page replacement block
package lru_pr_pkg;

  localparam int LRU_WAYS      = 4;
  localparam int LRU_PAGE_BITS = 16;
  localparam int LRU_POS_W     = (LRU_WAYS > 2) ? $clog2(LRU_WAYS) : 1;
  localparam int LRU_OCC_W     = $clog2(LRU_WAYS + 1);
  localparam int IO_PAGE_W     = 16;
  localparam int IO_POS_W      = 2;

  typedef logic [LRU_PAGE_BITS-1:0] page_t;
  typedef logic [LRU_POS_W-1:0]     pos_t;
  typedef logic [LRU_OCC_W-1:0]     occ_t;

  // per-cell update controls
  typedef struct packed {
    logic shift;  // take the right neighbour's entry
    logic load;   // take the requested page
  } cell_ctrl_t;

  // port page to stored width: upper bits dropped, short ones zero-extended
  function automatic page_t page_from_port(input logic [IO_PAGE_W-1:0] p);
    logic [LRU_PAGE_BITS+IO_PAGE_W-1:0] tmp;
    tmp = {{LRU_PAGE_BITS{1'b0}}, p};
    return tmp[LRU_PAGE_BITS-1:0];
  endfunction

  function automatic logic [IO_PAGE_W-1:0] page_to_port(input page_t p);
    logic [LRU_PAGE_BITS+IO_PAGE_W-1:0] tmp;
    tmp = {{IO_PAGE_W{1'b0}}, p};
    return tmp[IO_PAGE_W-1:0];
  endfunction

  function automatic logic [IO_POS_W-1:0] pos_to_port(input pos_t p);
    logic [LRU_POS_W+IO_POS_W-1:0] tmp;
    tmp = {{IO_POS_W{1'b0}}, p};
    return tmp[IO_POS_W-1:0];
  endfunction

endpackage

// File: rtl/lru_pr_if.sv
// request and result channel interfaces
interface lru_pr_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] page;

  modport source (output valid, output page, input ready);
  modport sink   (input valid, input page, output ready);
endinterface

interface lru_pr_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic        evicted;
  logic [15:0] evicted_page;
  logic [1:0]  old_position;
  logic [1:0]  new_position;

  modport source (output valid, output hit, output evicted, output evicted_page,
                  output old_position, output new_position, input ready);
  modport sink   (input valid, input hit, input evicted, input evicted_page,
                  input old_position, input new_position, output ready);
endinterface

// File: rtl/lru_pr_cell.sv
// one recency slot: holds a page, compares it, shifts or loads on update
module lru_pr_cell
  import lru_pr_pkg::*;
(
  input  logic       clk,
  input  logic       valid,
  input  page_t      req_page,
  input  page_t      right_page,
  input  cell_ctrl_t ctrl,
  output page_t      entry,
  output logic       match
);

  page_t entry_r;
  page_t entry_nxt;

  assign entry = entry_r;
  assign match = valid && (entry_r == req_page);

  always_comb begin
    priority if (ctrl.load) begin
      entry_nxt = req_page;
    end else if (ctrl.shift) begin
      entry_nxt = right_page;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// File: rtl/lru_page_replacement.sv
// top level: lru page store built as a row of shifting cells
//
//   channel | dir | handshake           | payload
//   in_ch   | in  | valid / ready       | page
//   out_ch  | out | valid / ready       | hit, evicted, evicted_page,
//           |     |                     | old_position, new_position
//
// one beat per cycle unless out_ch stalls: all cells compare in parallel
// and shift in the same cycle; the result is registered from that beat.
// a new request is taken when no result is held or the held one is taken.
// reset clears the occupancy count and the result valid; cell contents are
// only read below the occupancy count.
// out_ch stalled with a result held stalls in_ch.
module lru_page_replacement
  import lru_pr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  lru_pr_in_if.sink    in_ch,
  lru_pr_out_if.source out_ch
);

  occ_t       occ_r;
  occ_t       occ_nxt;
  logic       out_valid_r;
  logic       hit_r;
  logic       evicted_r;
  logic [IO_PAGE_W-1:0] evicted_page_r;
  logic [IO_POS_W-1:0]  old_pos_r;
  logic [IO_POS_W-1:0]  new_pos_r;

  page_t      req_page;
  page_t      entries   [LRU_WAYS];
  page_t      right_pg  [LRU_WAYS];
  logic       cell_vld  [LRU_WAYS];
  logic       match     [LRU_WAYS];
  cell_ctrl_t ctrl      [LRU_WAYS];
  logic       any_hit;
  pos_t       found;
  logic       full;
  logic       accept;
  occ_t       new_pos_occ;

  assign req_page     = page_from_port(in_ch.page);
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign full         = (occ_r == occ_t'(LRU_WAYS));

  genvar g;
  generate
    for (g = 0; g < LRU_WAYS; g++) begin : g_cell
      assign cell_vld[g] = (occ_t'(g) < occ_r);
      if (g == LRU_WAYS - 1) begin : g_last
        assign right_pg[g] = '0;
      end else begin : g_mid
        assign right_pg[g] = entries[g+1];
      end
      lru_pr_cell u_cell (
        .clk        (clk),
        .valid      (cell_vld[g]),
        .req_page   (req_page),
        .right_page (right_pg[g]),
        .ctrl       (ctrl[g]),
        .entry      (entries[g]),
        .match      (match[g])
      );
    end
  endgenerate

  // lowest matching slot
  always_comb begin
    any_hit = 1'b0;
    found   = '0;
    for (int i = LRU_WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        any_hit = 1'b1;
        found   = pos_t'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < LRU_WAYS; i++) begin
      ctrl[i] = '0;
      if (accept) begin
        priority if (any_hit) begin
          ctrl[i].shift = (pos_t'(i) >= found) && (occ_t'(i + 1) < occ_r);
          ctrl[i].load  = (occ_t'(i + 1) == occ_r);
        end else if (full) begin
          ctrl[i].shift = (i < LRU_WAYS - 1);
          ctrl[i].load  = (i == LRU_WAYS - 1);
        end else begin
          ctrl[i].load  = (occ_t'(i) == occ_r);
        end
      end
    end
  end

  assign occ_nxt     = (any_hit || full) ? occ_r : occ_r + occ_t'(1);
  assign new_pos_occ = occ_nxt - occ_t'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        occ_r       <= occ_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit_r          <= any_hit;
      evicted_r      <= !any_hit && full;
      evicted_page_r <= (!any_hit && full) ? page_to_port(entries[0]) : '0;
      old_pos_r      <= any_hit ? pos_to_port(found) : '0;
      new_pos_r      <= pos_to_port(new_pos_occ[LRU_POS_W-1:0]);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.hit          = hit_r;
  assign out_ch.evicted      = evicted_r;
  assign out_ch.evicted_page = evicted_page_r;
  assign out_ch.old_position = old_pos_r;
  assign out_ch.new_position = new_pos_r;

endmodule

// File: sim/tb_top.sv
// self-checking testbench for the lru page replacement block
`timescale 1ns / 1ps

module tb_top;
  import lru_pr_pkg::*;

  localparam int N_RANDOM   = 1100;
  localparam int WDOG_LIMIT = 4000;
  localparam int MAX_SHOWN  = 10;

  typedef struct packed {
    logic        hit;
    logic        evicted;
    logic [15:0] evicted_page;
    logic [1:0]  old_position;
    logic [1:0]  new_position;
  } lru_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lru_pr_in_if  in_if ();
  lru_pr_out_if out_if ();

  lru_page_replacement dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #4 clk = ~clk;

  // predictor state: recency-ordered pages, index 0 least recent
  page_t lru_store [LRU_WAYS];
  int    lru_occ = 0;

  logic [15:0] page_queue [$];
  lru_result_t expected_results [$];

  int n_total = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_hits = 0;
  int n_evictions = 0;
  int n_errors = 0;
  int idle_cycles = 0;
  int send_idle_pct;
  int recv_idle_pct;

  function automatic lru_result_t lru_access(input logic [15:0] req);
    lru_result_t r;
    page_t       p;
    int          found;
    int          n;
    r = '0;
    p = page_from_port(req);
    found = -1;
    n = lru_occ;
    for (int i = 0; i < n; i++) begin
      if (found < 0 && lru_store[i] == p) found = i;
    end
    if (found >= 0) begin
      r.hit = 1'b1;
      r.old_position = 2'(found);
      for (int i = found; i < n - 1; i++) lru_store[i] = lru_store[i + 1];
      lru_store[n - 1] = p;
    end else if (n == LRU_WAYS) begin
      r.evicted = 1'b1;
      r.evicted_page = 16'(lru_store[0]);
      for (int i = 0; i < LRU_WAYS - 1; i++) lru_store[i] = lru_store[i + 1];
      lru_store[LRU_WAYS - 1] = p;
    end else begin
      lru_store[n] = p;
      n++;
    end
    lru_occ = n;
    r.new_position = 2'(n - 1);
    return r;
  endfunction

  // idle mix follows how far the stimulus has got
  always_comb begin
    if (n_accepted < n_total / 3) begin
      send_idle_pct = 26;
      recv_idle_pct = 54;
    end else if (n_accepted < (2 * n_total) / 3) begin
      send_idle_pct = 54;
      recv_idle_pct = 26;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.page = '0;
    out_if.ready = 1'b0;
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.page <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_results.insert(expected_results.size(), lru_access(in_if.page));
        n_accepted++;
      end
      if (in_if.valid && !in_if.ready) begin
        // hold the beat until it is taken
      end else if (page_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_if.valid <= 1'b1;
        in_if.page <= page_queue.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    lru_result_t got;
    lru_result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.hit, out_if.evicted, out_if.evicted_page,
                out_if.old_position, out_if.new_position};
        if (expected_results.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_SHOWN)
            $display("unexpected result beat: %p", got);
        end else begin
          want = expected_results.pop_front();
          n_checked++;
          if (want.hit) n_hits++;
          if (want.evicted) n_evictions++;
          if (got !== want) begin
            n_errors++;
            if (n_errors <= MAX_SHOWN)
              $display("result %0d mismatch: expected %p, got %p", n_checked, want, got);
          end
        end
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WDOG_LIMIT);
      $display("tb_top: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [15:0] pool [8];
    int          pool_n;
    // empty store, repeat on a single entry, fill to four, then every hit position
    page_queue = '{16'h0000, 16'h0000, 16'hFFFF, 16'h5A5A, 16'hA5A5,
                   16'hA5A5, 16'h0000, 16'h5A5A, 16'h8001, 16'h7FFE,
                   16'h7FFE, 16'h0001, 16'h8000, 16'h0001, 16'hFFFF,
                   16'h8000, 16'h1234, 16'h8000};
    pool_n = 4;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 50 == 0) begin
        // small working sets give hit runs, larger ones steady eviction
        pool_n = $urandom_range(2, 8);
        foreach (pool[k]) pool[k] = 16'($urandom);
      end
      if ($urandom_range(99) < 80)
        page_queue.insert(page_queue.size(), pool[$urandom_range(pool_n - 1)]);
      else
        page_queue.insert(page_queue.size(), 16'($urandom));
    end
    n_total = page_queue.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (page_queue.size() != 0 || in_if.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (expected_results.size() != 0) begin
      n_errors += expected_results.size();
      $display("%0d expected results never arrived", expected_results.size());
    end
    $display("requests sent %0d, results checked %0d", n_accepted, n_checked);
    $display("hits %0d, evictions %0d, mismatches %0d", n_hits, n_evictions, n_errors);
    if (n_errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
